// ===== rtl/sorted_topk_candidate_list_assert.svh =====
// Assertion macros used by the checker file
`ifndef SORTED_TOPK_CANDIDATE_LIST_ASSERT_SVH
`define SORTED_TOPK_CANDIDATE_LIST_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define STK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define STK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/stk_pkg.sv =====
package stk_pkg;

  localparam int DEPTH      = 64;
  localparam int ID_BITS    = 24;
  localparam int SCORE_BITS = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = 7;
  localparam int OP_W       = 2;
  localparam int STAT_W     = 3;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_REJECTED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_POPPED    = 3'd2;
  localparam logic [STAT_W-1:0] ST_POP_EMPTY = 3'd3;
  localparam logic [STAT_W-1:0] ST_CLEARED   = 3'd4;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                         cmp_en;
    logic                         ins_en;
    logic                         pop_en;
    logic [ID_BITS-1:0]           id;
    logic signed [SCORE_BITS-1:0] score;
    logic [CNT_W-1:0]             count;
    logic [IDX_W-1:0]             last_idx;
  } cell_ctrl_t;

  // saturate a written length to 1..DEPTH
  function automatic logic [CNT_W-1:0] clamp_len(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    else if (v > CNT_W'(DEPTH)) r = CNT_W'(DEPTH);
    return r;
  endfunction

endpackage

// ===== rtl/sorted_topk_candidate_list.sv =====
// Channel  | Port group          | Contents (low bit first)
// in       | s_tvalid/s_tready   | tuser: operation; tdata: item_id, item_score
// out      | m_tvalid/m_tready   | tuser: status; tdata: out_id, out_score, occupancy, pad
// config   | cfg_wr_en           | cfg_wr_data: list_length
//
// Each item is first compared against all slots in the cell row, then the
// row is shifted and the result register loaded in the update step.
// A new item is taken in the update step, so one item can enter while the last one finishes.
// rst is synchronous: list empty, list_length = 64.
// While a result waits on m_tready one more item is taken and compared;
// its update then holds until the output register frees.
module sorted_topk_candidate_list (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // item_id[23:0], item_score[55:24]
  input  logic [1:0]  s_tuser,   // operation[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // out_id[23:0], out_score[55:24], occupancy[62:56], 0
  output logic [2:0]  m_tuser,   // status[2:0]
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data
);

  localparam int ID_BITS    = stk_pkg::ID_BITS;
  localparam int SCORE_BITS = stk_pkg::SCORE_BITS;
  localparam int CNT_W      = stk_pkg::CNT_W;
  localparam int DEPTH      = stk_pkg::DEPTH;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]                  state, state_next;
  logic [stk_pkg::OP_W-1:0]    op_q;
  logic [ID_BITS-1:0]          id_q;
  logic signed [SCORE_BITS-1:0] score_q;
  logic [CNT_W-1:0]            valid_count, valid_count_next;
  logic [CNT_W-1:0]            list_len;
  logic [CNT_W-1:0]            cfg_len;

  logic                        accept, upd_go, reject;
  logic [stk_pkg::STAT_W-1:0]  stat_next;
  logic [ID_BITS-1:0]          oid_next;
  logic [SCORE_BITS-1:0]       osc_next;
  stk_pkg::cell_ctrl_t         ctrl;

  logic [ID_BITS-1:0]           cell_id    [DEPTH];
  logic signed [SCORE_BITS-1:0] cell_score [DEPTH];
  logic [DEPTH-1:0]             cell_keep;
  logic [DEPTH-1:0]             cell_last_gt;

  // handshake
  assign upd_go   = (state == S_UPD) && (!m_tvalid || m_tready);
  assign s_tready = (state == S_IDLE) || upd_go;
  assign accept   = s_tvalid && s_tready;
  assign cfg_len  = stk_pkg::clamp_len(cfg_wr_data);

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_CMP;
      S_CMP:  state_next = S_UPD;
      S_UPD: begin
        if (upd_go) state_next = accept ? S_CMP : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // pending item
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= s_tuser;
      id_q    <= s_tdata[ID_BITS-1:0];
      score_q <= s_tdata[ID_BITS+SCORE_BITS-1:ID_BITS];
    end
  end

  // full list and the new score is below the last entry
  assign reject = (valid_count >= list_len) && (|cell_last_gt);

  // result and new count
  always_comb begin
    stat_next        = stk_pkg::ST_REJECTED;
    oid_next         = '0;
    osc_next         = '0;
    valid_count_next = valid_count;
    case (op_q)
      stk_pkg::OP_INSERT: begin
        if (!reject) begin
          stat_next = stk_pkg::ST_INSERTED;
          if (valid_count < list_len) valid_count_next = valid_count + CNT_W'(1);
        end
      end
      stk_pkg::OP_POP: begin
        if (valid_count == '0) begin
          stat_next = stk_pkg::ST_POP_EMPTY;
        end else begin
          stat_next        = stk_pkg::ST_POPPED;
          oid_next         = cell_id[0];
          osc_next         = cell_score[0];
          valid_count_next = valid_count - CNT_W'(1);
        end
      end
      stk_pkg::OP_CLEAR: begin
        stat_next        = stk_pkg::ST_CLEARED;
        valid_count_next = '0;
      end
      default: ;
    endcase
  end

  // cell row control
  always_comb begin
    ctrl.cmp_en   = (state == S_CMP);
    ctrl.ins_en   = upd_go && (op_q == stk_pkg::OP_INSERT) && !reject;
    ctrl.pop_en   = upd_go && (op_q == stk_pkg::OP_POP) && (valid_count != '0);
    ctrl.id       = id_q;
    ctrl.score    = score_q;
    ctrl.count    = valid_count;
    ctrl.last_idx = stk_pkg::IDX_W'(list_len - CNT_W'(1));
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      valid_count <= '0;
      list_len    <= CNT_W'(DEPTH);
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        list_len <= cfg_len;
        if (valid_count > cfg_len) valid_count <= cfg_len;
      end else if (upd_go) begin
        valid_count <= valid_count_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (upd_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      m_tuser <= stat_next;
      m_tdata <= {1'b0, valid_count_next, osc_next, oid_next};
    end
  end

  // cell row
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                         pk;
    logic [ID_BITS-1:0]           pid, nid;
    logic signed [SCORE_BITS-1:0] psc, nsc;

    if (g == 0) begin : g_first
      assign pk  = 1'b1;
      assign pid = id_q;
      assign psc = score_q;
    end else begin : g_mid
      assign pk  = cell_keep[g-1];
      assign pid = cell_id[g-1];
      assign psc = cell_score[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign nid = cell_id[g];
      assign nsc = cell_score[g];
    end else begin : g_inner
      assign nid = cell_id[g+1];
      assign nsc = cell_score[g+1];
    end

    stk_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (stk_pkg::IDX_W'(g)),
      .prev_keep  (pk),
      .prev_id    (pid),
      .prev_score (psc),
      .next_id    (nid),
      .next_score (nsc),
      .keep       (cell_keep[g]),
      .last_gt    (cell_last_gt[g]),
      .id         (cell_id[g]),
      .score      (cell_score[g])
    );
  end

endmodule

// ===== rtl/stk_cell.sv =====
// One list slot: holds an entry, compares it against the pending item,
// and on update keeps, takes the new item, or takes a neighbor's entry.
module stk_cell (
  input  logic                                 clk,
  input  stk_pkg::cell_ctrl_t                  ctrl,
  input  logic [stk_pkg::IDX_W-1:0]            idx,
  input  logic                                 prev_keep,
  input  logic [stk_pkg::ID_BITS-1:0]          prev_id,
  input  logic signed [stk_pkg::SCORE_BITS-1:0] prev_score,
  input  logic [stk_pkg::ID_BITS-1:0]          next_id,
  input  logic signed [stk_pkg::SCORE_BITS-1:0] next_score,
  output logic                                 keep,
  output logic                                 last_gt,
  output logic [stk_pkg::ID_BITS-1:0]          id,
  output logic signed [stk_pkg::SCORE_BITS-1:0] score
);

  logic ge_q;
  logic gt_q;

  // compare phase: flags against the pending item
  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      ge_q <= $signed(score) >= $signed(ctrl.score);
      gt_q <= $signed(score) >  $signed(ctrl.score);
    end
  end

  // entry stays put when it is an active slot before the last one and ranks at or above the new item
  assign keep = ge_q && ({1'b0, idx} < ctrl.count) && (idx < ctrl.last_idx);
  // last slot of the configured length beats the new item
  assign last_gt = gt_q && (idx == ctrl.last_idx);

  // update phase: keep, take new, or shift
  always_ff @(posedge clk) begin
    if (ctrl.ins_en) begin
      if (!keep) begin
        if (prev_keep) begin
          id    <= ctrl.id;
          score <= ctrl.score;
        end else begin
          id    <= prev_id;
          score <= prev_score;
        end
      end
    end else if (ctrl.pop_en) begin
      id    <= next_id;
      score <= next_score;
    end
  end

endmodule

// ===== rtl/stk_checker.sv =====
`include "sorted_topk_candidate_list_assert.svh"

// Port-level checks on the result stream
module stk_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [2:0]  m_tuser
);

  // a stalled result stays offered
  `STK_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

  // occupancy never exceeds the slot count
  `STK_ASSERT_NOW(a_occ_max, m_tvalid, m_tdata[62:56] <= 7'(stk_pkg::DEPTH), "occupancy too big")

  // a clear leaves the list empty
  `STK_ASSERT_NOW(a_clear_empty, m_tvalid && m_tuser == stk_pkg::ST_CLEARED, m_tdata[62:56] == '0, "clear left entries")

  // pop on empty reports no entry and an empty list
  `STK_ASSERT_NOW(a_pop_empty, m_tvalid && m_tuser == stk_pkg::ST_POP_EMPTY, m_tdata[62:0] == '0, "bad empty pop")

  // only pops carry an entry
  `STK_ASSERT_NOW(a_data_pop, m_tvalid && m_tuser != stk_pkg::ST_POPPED, m_tdata[55:0] == '0, "entry on non-pop")

endmodule

bind sorted_topk_candidate_list stk_checker u_stk_checker (.*);

// ===== verif/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OP_W       = stk_pkg::OP_W;
  localparam int ID_BITS    = stk_pkg::ID_BITS;
  localparam int SCORE_BITS = stk_pkg::SCORE_BITS;
  localparam int STAT_W     = stk_pkg::STAT_W;
  localparam int CNT_W      = stk_pkg::CNT_W;
  localparam int DEPTH      = stk_pkg::DEPTH;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 1000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 200;

  typedef struct {
    logic [OP_W-1:0]              op;
    logic [ID_BITS-1:0]           id;
    logic signed [SCORE_BITS-1:0] score;
  } cand_t;

  typedef struct {
    logic [STAT_W-1:0]            status;
    logic [ID_BITS-1:0]           id;
    logic signed [SCORE_BITS-1:0] score;
    logic [CNT_W-1:0]             occ;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;   // item_id[23:0], item_score[55:24]
  logic [1:0]  s_tuser = '0;   // operation[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // out_id[23:0], out_score[55:24], occupancy[62:56], 0
  logic [2:0]  m_tuser;        // status[2:0]
  logic        cfg_wr_en = 1'b0;
  logic [6:0]  cfg_wr_data = '0;

  sorted_topk_candidate_list u_top (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // candidates waiting to be sent, and results owed by the block
  cand_t    cand_q[$];
  outcome_t outcome_q[$];
  int       err_cnt = 0;

  // idling knobs, set per phase
  int gap_max = 0;
  int stall_pct = 0;
  int burst_left = 1;
  int gap_left = 0;
  int hold_left = 0;

  // shadow copy of the sorted list
  logic [ID_BITS-1:0]           list_ids [DEPTH];
  logic signed [SCORE_BITS-1:0] list_scores [DEPTH];
  int                           list_count = 0;
  logic [CNT_W-1:0]             list_len = CNT_W'(DEPTH);

  // list length actually in force: 0 acts as 1, above DEPTH acts as DEPTH
  function automatic int active_len();
    if (list_len == '0) return 1;
    if (int'(list_len) > DEPTH) return DEPTH;
    return int'(list_len);
  endfunction

  // apply one candidate to the shadow list and return the result it causes
  function automatic outcome_t rank_update(cand_t c);
    outcome_t r;
    int k, n, p, j, last;
    r.status = stk_pkg::ST_REJECTED;
    r.id = '0;
    r.score = '0;
    k = active_len();
    n = (list_count > k) ? k : list_count;
    case (c.op)
      stk_pkg::OP_INSERT: begin
        if (n >= k && c.score < list_scores[k-1]) begin
          r.status = stk_pkg::ST_REJECTED;
        end else begin
          // goes after every entry of equal or higher score, but never past the last slot
          p = 0;
          while (p < n && p < k - 1 && list_scores[p] >= c.score) p++;
          last = (n < k) ? n : k - 1;
          for (j = last; j > p; j--) begin
            list_ids[j] = list_ids[j-1];
            list_scores[j] = list_scores[j-1];
          end
          list_ids[p] = c.id;
          list_scores[p] = c.score;
          if (n < k) n++;
          r.status = stk_pkg::ST_INSERTED;
        end
      end
      stk_pkg::OP_POP: begin
        if (n == 0) begin
          r.status = stk_pkg::ST_POP_EMPTY;
        end else begin
          r.id = list_ids[0];
          r.score = list_scores[0];
          for (j = 0; j + 1 < n; j++) begin
            list_ids[j] = list_ids[j+1];
            list_scores[j] = list_scores[j+1];
          end
          n--;
          r.status = stk_pkg::ST_POPPED;
        end
      end
      stk_pkg::OP_CLEAR: begin
        n = 0;
        r.status = stk_pkg::ST_CLEARED;
      end
      default: ;
    endcase
    list_count = n;
    r.occ = CNT_W'(n);
    return r;
  endfunction

  // random candidate; scores lean on ties and extremes
  function automatic cand_t rand_cand(int ins_pct);
    cand_t c;
    int r;
    r = $urandom_range(99);
    if (r < ins_pct) c.op = stk_pkg::OP_INSERT;
    else if (r < 97) c.op = stk_pkg::OP_POP;
    else if (r < 98) c.op = stk_pkg::OP_CLEAR;
    else c.op = OP_UNUSED;
    c.id = ID_BITS'($urandom);
    case ($urandom_range(5))
      0, 1: c.score = SCORE_BITS'($urandom_range(8)) - 4;
      2: begin
        case ($urandom_range(5))
          0: c.score = 32'sh7fffffff;
          1: c.score = 32'sh7ffffffe;
          2: c.score = 32'sh80000000;
          3: c.score = 32'sh80000001;
          4: c.score = '0;
          default: c.score = '1;
        endcase
      end
      default: c.score = SCORE_BITS'($urandom);
    endcase
    return c;
  endfunction

  task automatic push_item(input logic [OP_W-1:0] op, input logic [ID_BITS-1:0] id,
                           input logic signed [SCORE_BITS-1:0] score);
    cand_t c;
    c.op = op;
    c.id = id;
    c.score = score;
    cand_q.insert(cand_q.size(), c);
  endtask

  // wait until everything sent has come back, then let the clock run on
  task automatic settle();
    while (cand_q.size() != 0 || outcome_q.size() != 0 || s_tvalid) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_length(input logic [CNT_W-1:0] v);
    settle();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    list_len = v;
    if (list_count > active_len()) list_count = active_len();
    @(negedge clk);
  endtask

  // sender: bursts of items with random gaps, holds an item until taken
  always @(posedge clk) begin
    outcome_t owed;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        owed = rank_update(cand_q.pop_front());
        outcome_q.insert(outcome_q.size(), owed);
      end
      if (!(s_tvalid && !s_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (cand_q.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= {cand_q[0].score, cand_q[0].id};
          s_tuser <= cand_q[0].op;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = (gap_max == 0) ? 0 : $urandom_range(gap_max);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stalls of random length started at random
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if ($urandom_range(99) < stall_pct) begin
      hold_left <= ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(6);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: result with none expected: status=%0d tdata=%h",
                 $time, m_tuser, m_tdata);
        err_cnt++;
      end else begin
        want = outcome_q.pop_front();
        if (m_tuser !== want.status || m_tdata[23:0] !== want.id ||
            m_tdata[55:24] !== want.score || m_tdata[62:56] !== want.occ) begin
          $display("%0t: expected status=%0d id=%h score=%0d occ=%0d", $time,
                   want.status, want.id, want.score, want.occ);
          $display("%0t: actual   status=%0d id=%h score=%0d occ=%0d", $time,
                   m_tuser, m_tdata[23:0], $signed(m_tdata[55:24]), m_tdata[62:56]);
          err_cnt++;
        end
      end
    end
  end

  // watchdog: too long with no item moving on either side
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("sorted_topk_candidate_list: mismatch");
    $finish;
  end

  initial begin : stimulus
    int lens[PHASES];
    int ins_pcts[PHASES];
    int gaps[PHASES];
    int stalls[PHASES];
    int ph, i;
    lens     = '{64, 1, 127, 3, 64, 0, 16, 64};
    ins_pcts = '{70, 60, 80, 65, 70, 60, 75, 85};
    gaps     = '{0, 3, 8, 2, 20, 1, 5, 0};
    stalls   = '{0, 20, 40, 10, 50, 5, 30, 0};
    lens[4]  = $urandom_range(1, 64);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // extremes, ties, unused op, clear, pop on empty; length at reset value
    push_item(stk_pkg::OP_POP, '0, '0);
    push_item(stk_pkg::OP_INSERT, 24'hffffff, 32'sh7fffffff);
    push_item(stk_pkg::OP_INSERT, 24'h000000, 32'sh80000000);
    push_item(stk_pkg::OP_INSERT, 24'd5, 32'sd0);
    push_item(stk_pkg::OP_INSERT, 24'd6, 32'sd0);
    push_item(OP_UNUSED, 24'd123, 32'sd77);
    push_item(stk_pkg::OP_POP, '0, '0);
    push_item(stk_pkg::OP_POP, '0, '0);
    push_item(stk_pkg::OP_CLEAR, '0, '0);
    push_item(stk_pkg::OP_POP, '0, '0);

    // full list: reject below last, replace on equal to last, drop on better
    set_length(7'd2);
    push_item(stk_pkg::OP_INSERT, 24'd1, 32'sd10);
    push_item(stk_pkg::OP_INSERT, 24'd2, 32'sd20);
    push_item(stk_pkg::OP_INSERT, 24'd3, 32'sd5);
    push_item(stk_pkg::OP_INSERT, 24'd4, 32'sd10);
    push_item(stk_pkg::OP_INSERT, 24'd5, 32'sd30);
    push_item(stk_pkg::OP_POP, '0, '0);

    // shrinking the length drops the tail
    set_length(7'd64);
    push_item(stk_pkg::OP_CLEAR, '0, '0);
    push_item(stk_pkg::OP_INSERT, 24'd11, 32'sd40);
    push_item(stk_pkg::OP_INSERT, 24'd12, 32'sd30);
    push_item(stk_pkg::OP_INSERT, 24'd13, 32'sd20);
    set_length(7'd2);
    push_item(stk_pkg::OP_POP, '0, '0);
    push_item(stk_pkg::OP_POP, '0, '0);
    push_item(stk_pkg::OP_POP, '0, '0);

    // zero length acts as one
    set_length(7'd0);
    push_item(stk_pkg::OP_INSERT, 24'd7, -32'sd1);
    push_item(stk_pkg::OP_INSERT, 24'd8, -32'sd2);
    push_item(stk_pkg::OP_INSERT, 24'd9, -32'sd1);
    push_item(stk_pkg::OP_POP, '0, '0);

    // random phases over lengths and idling patterns
    for (ph = 0; ph < PHASES; ph++) begin
      set_length(CNT_W'(lens[ph]));
      gap_max = gaps[ph];
      stall_pct = stalls[ph];
      for (i = 0; i < PHASE_ITEMS; i++) cand_q.insert(cand_q.size(), rand_cand(ins_pcts[ph]));
    end

    settle();
    if (err_cnt == 0) begin
      $display("sorted_topk_candidate_list: match");
    end else begin
      $display("sorted_topk_candidate_list: mismatch");
    end
    $finish;
  end

endmodule
